>>> hdl/hilbert_curve_point_generator_defines.svh
// Assertion helpers shared by the point generator RTL.
`ifndef HILBERT_CURVE_POINT_GENERATOR_DEFINES_SVH
`define HILBERT_CURVE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HCPG_ASSERT_IMP(label, clock, reset_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define HCPG_ASSERT_NEXT(label, clock, reset_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/hcpg_pkg.sv
package hcpg_pkg;

	localparam int MAX_ORDER_DEF      = 16;
	localparam int MAX_SEG_POINTS_DEF = 64;
	localparam int QUEUE_DEPTH        = 2;

	localparam int INDEX_W      = 32;
	localparam int ORDER_REG_W  = 5;
	localparam int POINTS_REG_W = 7;
	localparam int CFG_DATA_W   = 7;
	localparam int CFG_INDEX_W  = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_CURVE_ORDER        = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_POINTS_PER_SEGMENT = 1'd1;

	localparam logic [ORDER_REG_W-1:0]  ORDER_RESET  = 5'd4;
	localparam logic [POINTS_REG_W-1:0] POINTS_RESET = 7'd10;

	localparam logic CMD_POINT   = 1'b0;
	localparam logic CMD_SEGMENT = 1'b1;

	// Job descriptor handed from the index walker to the point emitter.
	typedef struct packed {
		logic seg;      // interpolate a segment
		logic bad;      // index out of range
		logic move_x;   // segment runs along x
		logic move_up;  // segment runs toward larger coordinate
	} job_ctl_t;

endpackage

>>> hdl/hilbert_curve_point_generator.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+----------------------------------------------
// input    | push / full                 | command, curve_index
// result   | empty / pop                 | coord_x, coord_y, last_point, bad_index
// config   | cfg_write (no wait)         | cfg_index, cfg_data
//
// Command 0 is walked in the front walker, which walks two curve levels a cycle; the
// back then emits its single result.
// Command 1 is emitted by the back emitter, one point a cycle unless the result side stalls.
// After reset and after every config write, full stays high while the bit-serial
// divider finds the per-point step of the segment offset.
// A two-entry job queue and the output register let either side stall on its own.
module hilbert_curve_point_generator #(
	parameter int MAX_ORDER      = hcpg_pkg::MAX_ORDER_DEF,
	parameter int MAX_SEG_POINTS = hcpg_pkg::MAX_SEG_POINTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// item transfer in
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  command,
	input  logic [hcpg_pkg::INDEX_W-1:0]          curve_index,
	// result transfer out
	output logic                                  empty,
	input  logic                                  pop,
	output logic [MAX_ORDER:0]                    coord_x,
	output logic [MAX_ORDER:0]                    coord_y,
	output logic                                  last_point,
	output logic                                  bad_index,
	// register writes
	input  logic                                  cfg_write,
	input  logic [hcpg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [hcpg_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int FW  = MAX_ORDER + 1;
	localparam int W   = MAX_ORDER + 2;
	localparam int OW  = $clog2(MAX_ORDER + 1);
	localparam int EW  = $clog2(MAX_ORDER + 2);
	localparam int DW  = $clog2(MAX_SEG_POINTS);
	localparam int ORW = hcpg_pkg::ORDER_REG_W;
	localparam int PRW = hcpg_pkg::POINTS_REG_W;
	localparam int CTW = $bits(hcpg_pkg::job_ctl_t);
	localparam int JW  = CTW + 2 * FW;

	// Config registers, as written.
	logic [ORW-1:0] curve_order_q;
	logic [PRW-1:0] points_q;
	// Divider has to rerun after reset and after any write.
	logic           restart_q;

	logic [OW-1:0]  order_eff;
	logic [PRW-1:0] n_eff;
	logic [DW-1:0]  divisor;
	logic [EW-1:0]  exponent;
	logic           div_busy;
	logic [W-1:0]   step_quot;
	logic [DW-1:0]  step_rem;
	logic           hold;

	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	hcpg_pkg::job_ctl_t f_ctl;
	logic [FW-1:0]      f_px;
	logic [FW-1:0]      f_py;
	logic [JW-1:0]      q_wr_data;
	logic [JW-1:0]      q_rd_data;
	hcpg_pkg::job_ctl_t b_ctl;
	logic [FW-1:0]      b_px;
	logic [FW-1:0]      b_py;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_order_q <= hcpg_pkg::ORDER_RESET;
			points_q      <= hcpg_pkg::POINTS_RESET;
			restart_q     <= 1'b1;
		end else begin
			restart_q <= cfg_write;
			if (cfg_write) begin
				unique case (cfg_index)
					hcpg_pkg::REG_CURVE_ORDER:        curve_order_q <= cfg_data[ORW-1:0];
					hcpg_pkg::REG_POINTS_PER_SEGMENT: points_q      <= cfg_data[PRW-1:0];
					default: ;
				endcase
			end
		end
	end

	// Clamp order to the build limit and the point count to 2..MAX_SEG_POINTS.
	assign order_eff = (curve_order_q > ORW'(MAX_ORDER)) ? OW'(MAX_ORDER) : OW'(curve_order_q);

	always_comb begin
		if (points_q < PRW'(2)) begin
			n_eff = PRW'(2);
		end else if (points_q > PRW'(MAX_SEG_POINTS)) begin
			n_eff = PRW'(MAX_SEG_POINTS);
		end else begin
			n_eff = points_q;
		end
	end

	assign divisor  = DW'(n_eff - PRW'(1));
	// cell size = 2^(MAX_ORDER+1-order) in coordinate LSBs
	assign exponent = EW'(MAX_ORDER + 1) - EW'(order_eff);
	assign hold     = restart_q || div_busy;

	hcpg_step_div #(
		.MAX_ORDER      (MAX_ORDER),
		.MAX_SEG_POINTS (MAX_SEG_POINTS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (restart_q),
		.exponent (exponent),
		.divisor  (divisor),
		.busy     (div_busy),
		.quot     (step_quot),
		.rem      (step_rem)
	);

	hcpg_front #(
		.MAX_ORDER (MAX_ORDER)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.curve_index (curve_index),
		.order       (order_eff),
		.hold        (hold),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_ctl       (f_ctl),
		.q_px        (f_px),
		.q_py        (f_py)
	);

	assign q_wr_data = {f_ctl, f_px, f_py};

	hcpg_fifo #(
		.WIDTH (JW),
		.DEPTH (hcpg_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	assign b_ctl = q_rd_data[JW-1:2*FW];
	assign b_px  = q_rd_data[2*FW-1:FW];
	assign b_py  = q_rd_data[FW-1:0];

	hcpg_back #(
		.MAX_ORDER      (MAX_ORDER),
		.MAX_SEG_POINTS (MAX_SEG_POINTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_ctl      (b_ctl),
		.q_px       (b_px),
		.q_py       (b_py),
		.divisor    (divisor),
		.step_quot  (step_quot),
		.step_rem   (step_rem),
		.exponent   (exponent),
		.empty      (empty),
		.pop        (pop),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.last_point (last_point),
		.bad_index  (bad_index)
	);

endmodule

>>> hdl/hcpg_fifo.sv
module hcpg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = hcpg_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

>>> hdl/hcpg_step_div.sv
`include "hilbert_curve_point_generator_defines.svh"

// Bit-serial restoring division of 2^exponent by divisor, one quotient bit a cycle.
module hcpg_step_div #(
	parameter int MAX_ORDER      = hcpg_pkg::MAX_ORDER_DEF,
	parameter int MAX_SEG_POINTS = hcpg_pkg::MAX_SEG_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [$clog2(MAX_ORDER+2)-1:0]      exponent,
	input  logic [$clog2(MAX_SEG_POINTS)-1:0]   divisor,
	output logic                                busy,
	output logic [MAX_ORDER+1:0]                quot,
	output logic [$clog2(MAX_SEG_POINTS)-1:0]   rem
);

	localparam int W  = MAX_ORDER + 2;
	localparam int EW = $clog2(W);
	localparam int DW = $clog2(MAX_SEG_POINTS);

	logic          busy_q;
	logic [EW-1:0] bit_q;
	logic [W-1:0]  quot_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, (bit_q == exponent)};
	assign ge    = (trial >= {1'b0, divisor});
	assign diff  = trial - {1'b0, divisor};

	assign busy = busy_q;
	assign quot = quot_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
			quot_q <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			bit_q  <= EW'(W - 1);
			quot_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[W-2:0], ge};
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			if (bit_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				bit_q <= bit_q - EW'(1);
			end
		end
	end

	`HCPG_ASSERT_IMP(a_rem_below_div, clk, arst_n, !busy_q && !start, rem_q < divisor, "step remainder not below divisor")
	`HCPG_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q, "divider did not start")

endmodule

>>> hdl/hcpg_front.sv
`include "hilbert_curve_point_generator_defines.svh"

// Takes an item, checks its index, walks the curve digits two levels a cycle
// for both segment ends, then posts a job to the queue.
module hcpg_front #(
	parameter int MAX_ORDER = hcpg_pkg::MAX_ORDER_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             command,
	input  logic [hcpg_pkg::INDEX_W-1:0]     curve_index,
	input  logic [$clog2(MAX_ORDER+1)-1:0]   order,
	input  logic                             hold,
	input  logic                             q_full,
	output logic                             q_push,
	output hcpg_pkg::job_ctl_t               q_ctl,
	output logic [MAX_ORDER:0]               q_px,
	output logic [MAX_ORDER:0]               q_py
);

	localparam int CW = MAX_ORDER;
	localparam int FW = MAX_ORDER + 1;
	localparam int OW = $clog2(MAX_ORDER + 1);
	localparam int KW = $clog2(MAX_ORDER + 2);
	localparam int XW = hcpg_pkg::INDEX_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_PUSH = 2'd2;

	// One curve level: place the sub-curve in the quadrant named by digit q.
	function automatic logic [2*CW-1:0] walk_level(input logic [CW-1:0] x,
		input logic [CW-1:0] y, input logic [1:0] q, input logic [KW-1:0] k);
		logic [CW-1:0] s;
		logic [CW-1:0] nx;
		logic [CW-1:0] ny;
		s = CW'(1) << k;
		case (q)
			2'd0: begin
				nx = y;
				ny = x;
			end
			2'd1: begin
				nx = x + s;
				ny = y;
			end
			2'd2: begin
				nx = x + s;
				ny = y + s;
			end
			default: begin
				nx = s - CW'(1) - y;
				ny = (s << 1) - CW'(1) - x;
			end
		endcase
		return {nx, ny};
	endfunction

	function automatic logic [FW-1:0] centre(input logic [CW-1:0] c, input logic [OW-1:0] ord);
		return {c, 1'b1} << (OW'(MAX_ORDER) - ord);
	endfunction

	logic [1:0]    state_q;
	logic          cmd_q;
	logic          bad_q;
	logic [OW-1:0] order_q;
	logic [KW-1:0] k_q;
	logic [XW-1:0] ta_q;
	logic [XW-1:0] tb_q;
	logic [CW-1:0] xa_q;
	logic [CW-1:0] ya_q;
	logic [CW-1:0] xb_q;
	logic [CW-1:0] yb_q;

	logic            accept;
	logic            bad_in;
	logic [OW:0]     range_sh;
	logic [2*CW-1:0] a1;
	logic [2*CW-1:0] b1;
	logic [2*CW-1:0] a2;
	logic [2*CW-1:0] b2;
	logic            second_ok;
	logic            last_iter;
	logic            seg;

	assign full   = (state_q != S_IDLE) || hold;
	assign accept = push && !full;

	// 4^order points: anything at or above bit 2*order is out of range.
	assign range_sh = {order, 1'b0};
	assign bad_in   = ((curve_index >> range_sh) != '0) ||
		((command == hcpg_pkg::CMD_SEGMENT) && (curve_index == '0));

	assign second_ok = (k_q + KW'(1)) < KW'(order_q);
	assign last_iter = (k_q + KW'(2)) >= KW'(order_q);

	always_comb begin
		a1 = walk_level(xa_q, ya_q, ta_q[1:0], k_q);
		b1 = walk_level(xb_q, yb_q, tb_q[1:0], k_q);
		a2 = a1;
		b2 = b1;
		if (second_ok) begin
			a2 = walk_level(a1[2*CW-1:CW], a1[CW-1:0], ta_q[3:2], k_q + KW'(1));
			b2 = walk_level(b1[2*CW-1:CW], b1[CW-1:0], tb_q[3:2], k_q + KW'(1));
		end
	end

	assign seg            = (cmd_q == hcpg_pkg::CMD_SEGMENT) && !bad_q;
	assign q_push         = (state_q == S_PUSH) && !q_full;
	assign q_ctl.seg      = seg;
	assign q_ctl.bad      = bad_q;
	assign q_ctl.move_x   = (xa_q != xb_q);
	assign q_ctl.move_up  = (xa_q != xb_q) ? (xb_q > xa_q) : (yb_q > ya_q);
	assign q_px = bad_q ? '0 : (seg ? centre(xa_q, order_q) : centre(xb_q, order_q));
	assign q_py = bad_q ? '0 : (seg ? centre(ya_q, order_q) : centre(yb_q, order_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (bad_in || (order == '0)) ? S_PUSH : S_RUN;
					end
				end
				S_RUN: begin
					if (last_iter) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!q_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			bad_q   <= bad_in;
			order_q <= order;
			k_q     <= '0;
			ta_q    <= curve_index - XW'(1);
			tb_q    <= curve_index;
			xa_q    <= '0;
			ya_q    <= '0;
			xb_q    <= '0;
			yb_q    <= '0;
		end else if (state_q == S_RUN) begin
			{xa_q, ya_q} <= a2;
			{xb_q, yb_q} <= b2;
			ta_q <= {4'b0, ta_q[XW-1:4]};
			tb_q <= {4'b0, tb_q[XW-1:4]};
			k_q  <= k_q + KW'(2);
		end
	end

	`HCPG_ASSERT_IMP(a_walk_in_order, clk, arst_n, state_q == S_RUN, k_q < KW'(order_q), "curve walk ran past the order")

endmodule

>>> hdl/hcpg_back.sv
`include "hilbert_curve_point_generator_defines.svh"

// Pops jobs and emits their points one a cycle into the output register, unless the result side stalls.
// Offsets advance by quot + (remainder carry), giving floor(cell*j/d) exactly.
module hcpg_back #(
	parameter int MAX_ORDER      = hcpg_pkg::MAX_ORDER_DEF,
	parameter int MAX_SEG_POINTS = hcpg_pkg::MAX_SEG_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	output logic                               q_pop,
	input  hcpg_pkg::job_ctl_t                 q_ctl,
	input  logic [MAX_ORDER:0]                 q_px,
	input  logic [MAX_ORDER:0]                 q_py,
	input  logic [$clog2(MAX_SEG_POINTS)-1:0]  divisor,
	input  logic [MAX_ORDER+1:0]               step_quot,
	input  logic [$clog2(MAX_SEG_POINTS)-1:0]  step_rem,
	input  logic [$clog2(MAX_ORDER+2)-1:0]     exponent,
	output logic                               empty,
	input  logic                               pop,
	output logic [MAX_ORDER:0]                 coord_x,
	output logic [MAX_ORDER:0]                 coord_y,
	output logic                               last_point,
	output logic                               bad_index
);

	localparam int FW = MAX_ORDER + 1;
	localparam int W  = MAX_ORDER + 2;
	localparam int DW = $clog2(MAX_SEG_POINTS);

	logic               act_q;
	hcpg_pkg::job_ctl_t ctl_q;
	logic [FW-1:0]      px_q;
	logic [FW-1:0]      py_q;
	logic [DW-1:0]      j_q;
	logic [W-1:0]       off_q;
	logic [DW-1:0]      r_q;
	logic               out_valid_q;
	logic [FW-1:0]      out_x_q;
	logic [FW-1:0]      out_y_q;
	logic               out_last_q;
	logic               out_bad_q;

	logic          emit;
	logic          last_now;
	logic [W-1:0]  base;
	logic [W-1:0]  moved;
	logic [FW-1:0] nx;
	logic [FW-1:0] ny;
	logic [DW:0]   rsum;
	logic [DW:0]   rdiff;
	logic          wrap;

	assign emit     = act_q && (!out_valid_q || pop);
	assign last_now = !ctl_q.seg || (j_q == divisor);
	assign q_pop    = (!act_q || (emit && last_now)) && !q_empty;

	assign base  = ctl_q.move_x ? {1'b0, px_q} : {1'b0, py_q};
	assign moved = ctl_q.move_up ? base + off_q : base - off_q;
	assign nx    = (ctl_q.seg && ctl_q.move_x) ? moved[FW-1:0] : px_q;
	assign ny    = (ctl_q.seg && !ctl_q.move_x) ? moved[FW-1:0] : py_q;

	assign rsum  = {1'b0, r_q} + {1'b0, step_rem};
	assign wrap  = (rsum >= {1'b0, divisor});
	assign rdiff = rsum - {1'b0, divisor};

	assign empty      = !out_valid_q;
	assign coord_x    = out_x_q;
	assign coord_y    = out_y_q;
	assign last_point = out_last_q;
	assign bad_index  = out_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				act_q <= 1'b1;
			end else if (emit && last_now) begin
				act_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_q <= q_ctl;
			px_q  <= q_px;
			py_q  <= q_py;
			j_q   <= '0;
			off_q <= '0;
			r_q   <= '0;
		end else if (emit) begin
			j_q   <= j_q + DW'(1);
			off_q <= off_q + step_quot + W'(wrap);
			r_q   <= wrap ? rdiff[DW-1:0] : rsum[DW-1:0];
		end
		if (emit) begin
			out_x_q    <= nx;
			out_y_q    <= ny;
			out_last_q <= last_now;
			out_bad_q  <= ctl_q.bad;
		end
	end

	`HCPG_ASSERT_IMP(a_seg_lands_on_end, clk, arst_n, emit && ctl_q.seg && last_now, off_q == (W'(1) << exponent), "segment did not end one cell away")
	`HCPG_ASSERT_IMP(a_bad_is_zero_last, clk, arst_n, out_valid_q && out_bad_q, out_last_q && (out_x_q == '0) && (out_y_q == '0), "bad result not a zero last point")

endmodule
